>>> hw/rtl/i2cbe_pkg.sv
`default_nettype none

package i2cbe_pkg;

  localparam int unsigned DELAY_W = 10;
  localparam int unsigned STEP_W  = 3;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(60);
  localparam logic [CNT_W-1:0]   BITS_PER_BYTE = CNT_W'(8);

  // Command codes carried in the item's mode field.
  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_READ     = 3'd4,
    CMD_SEND_ACK = 3'd5,
    CMD_RECV_ACK = 3'd6,
    CMD_RECOVER  = 3'd7
  } cmd_e;

  typedef struct packed {
    logic              sda_in;
    logic              ack_bit;
    logic [BYTE_W-1:0] data_byte;
    cmd_e              mode;
  } item_t;

  typedef struct packed {
    logic              rejected;
    logic              ack_seen;
    logic [BYTE_W-1:0] read_byte;
    logic              done_res;
    logic              busy_res;
    logic              sda_level;
    logic              scl_level;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/i2cbe_seq.sv
`default_nettype none

module i2cbe_seq
  import i2cbe_pkg::*;
#(
  parameter int RECOVER_PULSES = 9
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [DELAY_W-1:0] cfg_wdata_i,
  input  wire logic               step_en_i,
  input  wire item_t              item_i,
  output res_t                    res_o
);

  localparam logic [CNT_W-1:0] PULSE_LIM = CNT_W'(RECOVER_PULSES);

  logic [DELAY_W-1:0] delay_q;
  logic               scl_q, scl_d, sda_q, sda_d;
  cmd_e               cmd_q, cmd_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [DELAY_W-1:0] dcnt_q, dcnt_d;
  logic [CNT_W-1:0]   bit_q, bit_d, pulse_q, pulse_d;
  logic [BYTE_W-1:0]  shift_q, shift_d, rx_q, rx_d;
  logic               ack_q, ack_d;

  logic               scl_a, sda_a, ack_a, fin, rej;
  logic [BYTE_W-1:0]  shift_a;
  logic [DELAY_W-1:0] dcnt_a;
  logic [CNT_W-1:0]   bit_inc, pulse_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_RST;
    end else if (cfg_we_i) begin
      delay_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    scl_d   = scl_q;
    sda_d   = sda_q;
    cmd_d   = cmd_q;
    step_d  = step_q;
    dcnt_d  = dcnt_q;
    bit_d   = bit_q;
    pulse_d = pulse_q;
    shift_d = shift_q;
    rx_d    = rx_q;
    ack_d   = ack_q;
    scl_a   = scl_q;
    sda_a   = sda_q;
    shift_a = shift_q;
    ack_a   = ack_q;
    dcnt_a  = dcnt_q;
    fin     = 1'b0;
    rej     = 1'b0;
    bit_inc   = bit_q + CNT_W'(1);
    pulse_inc = pulse_q + CNT_W'(1);

    if (item_i.mode != CMD_TICK) begin
      if (cmd_q != CMD_TICK) begin
        rej = 1'b1;
      end else begin
        // Load the command; pins and time stay put.
        cmd_d   = item_i.mode;
        step_d  = '0;
        dcnt_d  = '0;
        bit_d   = '0;
        pulse_d = '0;
        if (item_i.mode == CMD_WRITE) begin
          shift_d = item_i.data_byte;
        end else if (item_i.mode == CMD_SEND_ACK) begin
          shift_d = {{(BYTE_W-1){1'b0}}, item_i.ack_bit};
        end else begin
          shift_d = '0;
        end
      end
    end else if (cmd_q != CMD_TICK) begin
      // First tick of a phase: perform its action and arm the counter.
      if (dcnt_q == '0) begin
        case (cmd_q)
          CMD_START: begin
            if (step_q == 3'd0)      sda_a = 1'b1;
            else if (step_q == 3'd1) scl_a = 1'b1;
            else if (step_q == 3'd2) sda_a = 1'b0;
            else                     scl_a = 1'b0;
          end
          CMD_STOP: begin
            if (step_q == 3'd0)      sda_a = 1'b0;
            else if (step_q == 3'd1) scl_a = 1'b1;
            else                     sda_a = 1'b1;
          end
          CMD_WRITE: begin
            if (step_q == 3'd0)      sda_a = shift_q[BYTE_W-1];
            else if (step_q == 3'd1) scl_a = 1'b1;
            else                     scl_a = 1'b0;
          end
          CMD_READ: begin
            if (step_q == 3'd0)      sda_a = 1'b1;
            else if (step_q == 3'd1) scl_a = 1'b1;
            else if (step_q == 3'd2) shift_a = {shift_q[BYTE_W-2:0], item_i.sda_in};
            else                     scl_a = 1'b0;
          end
          CMD_SEND_ACK: begin
            if (step_q == 3'd0)      sda_a = shift_q[0];
            else if (step_q == 3'd1) scl_a = 1'b1;
            else                     scl_a = 1'b0;
          end
          CMD_RECV_ACK: begin
            if (step_q == 3'd0)      sda_a = 1'b1;
            else if (step_q == 3'd1) scl_a = 1'b1;
            else if (step_q == 3'd2) ack_a = item_i.sda_in;
            else                     scl_a = 1'b0;
          end
          default: begin
            if (step_q == 3'd0) sda_a = 1'b1;
            else if (step_q == 3'd1 || step_q == 3'd4 || step_q == 3'd6) scl_a = 1'b1;
            else if (step_q == 3'd2) shift_a = {{(BYTE_W-1){1'b0}}, item_i.sda_in};
            else if (step_q == 3'd3) scl_a = 1'b0;
            else if (step_q == 3'd5) sda_a = 1'b0;
            else                     sda_a = 1'b1;
          end
        endcase
        dcnt_a = (delay_q == '0) ? DELAY_W'(1) : delay_q;
      end

      scl_d   = scl_a;
      sda_d   = sda_a;
      shift_d = shift_a;
      ack_d   = ack_a;
      dcnt_d  = dcnt_a - DELAY_W'(1);

      // Phase over: advance to the next one.
      if (dcnt_d == '0) begin
        step_d = step_q + STEP_W'(1);
        case (cmd_q)
          CMD_START:    fin = (step_q >= 3'd3);
          CMD_STOP:     fin = (step_q >= 3'd2);
          CMD_SEND_ACK: fin = (step_q >= 3'd2);
          CMD_RECV_ACK: fin = (step_q >= 3'd3);
          CMD_WRITE: begin
            if (step_q >= 3'd2) begin
              shift_d = {shift_a[BYTE_W-2:0], 1'b0};
              bit_d   = bit_inc;
              fin     = (bit_inc >= BITS_PER_BYTE);
              step_d  = 3'd0;
            end
          end
          CMD_READ: begin
            if (step_q >= 3'd3) begin
              bit_d  = bit_inc;
              step_d = 3'd1;
              if (bit_inc >= BITS_PER_BYTE) begin
                fin  = 1'b1;
                rx_d = shift_a;
              end
            end
          end
          default: begin
            if (step_q == 3'd1) begin
              step_d = (pulse_q < PULSE_LIM) ? 3'd2 : 3'd5;
            end else if (step_q == 3'd2) begin
              step_d = (shift_a == '0) ? 3'd3 : 3'd5;
            end else if (step_q == 3'd4) begin
              pulse_d = pulse_inc;
              step_d  = (pulse_inc < PULSE_LIM) ? 3'd2 : 3'd5;
            end else if (step_q >= 3'd7) begin
              fin = 1'b1;
            end
          end
        endcase
        if (fin) begin
          cmd_d  = CMD_TICK;
          step_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      cmd_q   <= CMD_TICK;
      step_q  <= '0;
      dcnt_q  <= '0;
      bit_q   <= '0;
      pulse_q <= '0;
      shift_q <= '0;
      rx_q    <= '0;
      ack_q   <= 1'b0;
    end else if (step_en_i) begin
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      cmd_q   <= cmd_d;
      step_q  <= step_d;
      dcnt_q  <= dcnt_d;
      bit_q   <= bit_d;
      pulse_q <= pulse_d;
      shift_q <= shift_d;
      rx_q    <= rx_d;
      ack_q   <= ack_d;
    end
  end

  always_comb begin
    res_o.scl_level = scl_d;
    res_o.sda_level = sda_d;
    res_o.busy_res  = (cmd_d != CMD_TICK);
    res_o.done_res  = fin;
    res_o.read_byte = rx_d;
    res_o.ack_seen  = ack_d;
    res_o.rejected  = rej;
  end

endmodule

`default_nettype wire

>>> hw/rtl/i2c_master_bit_engine.sv
// I2C master pin sequencer for a bit-banged open-drain bus.
// Slave channel (s_axis_*): one item per tick or command. tuser carries the
// mode (0 tick, 1 start, 2 stop, 3 write, 4 read, 5 send ack, 6 receive ack,
// 7 recover); tdata carries data_byte, ack_bit and the sampled sda_in.
// Master channel (m_axis_*): exactly one result item per input item, giving
// the SCL/SDA drive levels, busy, done, last read byte, last ack sample and a
// rejected flag for commands that arrived while a command was running.
// Config: cfg_we_i writes delay_ticks (ticks per phase) from cfg_wdata_i;
// write only while idle.
// Path: an item is taken into the input register, and its result is moved from
// there into the result register when the item advances. Throughput is one
// item per cycle while m_axis_tready_i stays high; the sequencer step
// is a single pass of logic between the input register and the result register.
// Reset: both lines released, no command active, delay_ticks = 60, no
// items held on either channel.
// Stall: when m_axis_tready_i is low, the result register holds, the input
// register holds one more item, and s_axis_tready_o then drops.
`default_nettype none

module i2c_master_bit_engine
  import i2cbe_pkg::*;
#(
  parameter int RECOVER_PULSES = 9
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [15:0]        s_axis_tdata_i,  // [7:0] data_byte, [8] ack_bit, [9] sda_in
  input  wire logic [2:0]         s_axis_tuser_i,  // [2:0] mode
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
  // [11:4] read_byte, [12] ack_seen, [13] rejected
  output logic [15:0]             m_axis_tdata_o,
  input  wire logic               cfg_we_i,
  input  wire logic [DELAY_W-1:0] cfg_wdata_i
);

  logic  in_valid_q, in_valid_d;
  item_t in_item_q;
  logic  out_valid_q, out_valid_d;
  res_t  out_res_q;
  res_t  seq_res;
  logic  s_accept, advance;

  // Advance the held item when the result register is free or being emptied.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register: take the item fields apart from the stream words.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q.mode      <= cmd_e'(s_axis_tuser_i);
      in_item_q.data_byte <= s_axis_tdata_i[7:0];
      in_item_q.ack_bit   <= s_axis_tdata_i[8];
      in_item_q.sda_in    <= s_axis_tdata_i[9];
    end
  end

  i2cbe_seq #(
    .RECOVER_PULSES(RECOVER_PULSES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_en_i  (advance),
    .item_i     (in_item_q),
    .res_o      (seq_res)
  );

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= seq_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00,
                            out_res_q.rejected,
                            out_res_q.ack_seen,
                            out_res_q.read_byte,
                            out_res_q.done_res,
                            out_res_q.busy_res,
                            out_res_q.sda_level,
                            out_res_q.scl_level};

endmodule

`default_nettype wire

>>> hw/rtl/i2cbe_checker.sv
`default_nettype none

module i2cbe_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result payload changed while stalled");

  // Input side only backs up when a result waits on a stalled receiver.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // A completing command leaves the engine idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[3] |-> !m_axis_tdata_o[2])
    else $error("done reported while still busy");

  // A rejected command was refused by a busy engine, and is not a completion.
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[13] |-> m_axis_tdata_o[2] && !m_axis_tdata_o[3])
    else $error("reject reported while idle or with done");

endmodule

bind i2c_master_bit_engine i2cbe_checker u_i2cbe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

`default_nettype wire

>>> bench/i2c_master_bit_engine_checker.sv
module i2c_master_bit_engine_checker
  import i2cbe_pkg::*;
#(
  parameter int RECOVER_PULSES = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [15:0]        s_tdata_i,  // [7:0] data_byte, [8] ack_bit, [9] sda_in
  input  logic [2:0]         s_tuser_i,  // [2:0] mode
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [15:0]        m_tdata_i,  // [0] scl, [1] sda, [2] busy, [3] done,
                                         // [11:4] read_byte, [12] ack_seen, [13] rejected
  input  logic               cfg_we_i,
  input  logic [DELAY_W-1:0] cfg_wdata_i,
  output logic               busy_o,
  output int                 pending_o,
  output int                 errors_o,
  output int                 items_o,
  output int                 done_o,
  output int                 rejects_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Sequencer copy; CMD_TICK in cmd_q means no command is running.
  logic [DELAY_W-1:0] delay_cfg;
  logic               scl_q, sda_q, ack_q;
  cmd_e               cmd_q;
  logic [5:0]         phase_q;
  logic [DELAY_W-1:0] wait_q;
  logic [3:0]         bit_q, pulse_q;
  logic [7:0]         shift_q, rx_q;

  res_t pin_result_q[$];
  res_t want, got;
  int   n_err, n_items, n_done, n_rej;

  // Act on the first tick of the current phase.
  function automatic void run_phase(logic line);
    case (cmd_q)
      CMD_START:
        case (phase_q)
          6'd0:    sda_q = 1'b1;
          6'd1:    scl_q = 1'b1;
          6'd2:    sda_q = 1'b0;
          default: scl_q = 1'b0;
        endcase
      CMD_STOP:
        case (phase_q)
          6'd0:    sda_q = 1'b0;
          6'd1:    scl_q = 1'b1;
          default: sda_q = 1'b1;
        endcase
      CMD_WRITE:
        case (phase_q)
          6'd0:    sda_q = shift_q[7];
          6'd1:    scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
      CMD_READ:
        case (phase_q)
          6'd0:    sda_q = 1'b1;
          6'd1:    scl_q = 1'b1;
          6'd2:    shift_q = {shift_q[6:0], line};
          default: scl_q = 1'b0;
        endcase
      CMD_SEND_ACK:
        case (phase_q)
          6'd0:    sda_q = shift_q[0];
          6'd1:    scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
      CMD_RECV_ACK:
        case (phase_q)
          6'd0:    sda_q = 1'b1;
          6'd1:    scl_q = 1'b1;
          6'd2:    ack_q = line;
          default: scl_q = 1'b0;
        endcase
      default:
        case (phase_q)
          6'd0:             sda_q = 1'b1;
          6'd1, 6'd4, 6'd6: scl_q = 1'b1;
          6'd2:             shift_q = {7'd0, line};
          6'd3:             scl_q = 1'b0;
          6'd5:             sda_q = 1'b0;
          default:          sda_q = 1'b1;
        endcase
    endcase
  endfunction

  // Advance to the next phase; return 1 once the command is complete.
  function automatic logic next_phase();
    case (cmd_q)
      CMD_START:    if (phase_q >= 6'd3) return 1'b1;
      CMD_STOP:     if (phase_q >= 6'd2) return 1'b1;
      CMD_SEND_ACK: if (phase_q >= 6'd2) return 1'b1;
      CMD_RECV_ACK: if (phase_q >= 6'd3) return 1'b1;
      CMD_WRITE:
        if (phase_q >= 6'd2) begin
          shift_q = {shift_q[6:0], 1'b0};
          bit_q   = bit_q + 4'd1;
          if (bit_q >= BITS_PER_BYTE) return 1'b1;
          phase_q = 6'd0;
          return 1'b0;
        end
      CMD_READ:
        if (phase_q >= 6'd3) begin
          bit_q = bit_q + 4'd1;
          if (bit_q >= BITS_PER_BYTE) begin
            rx_q = shift_q;
            return 1'b1;
          end
          phase_q = 6'd1;
          return 1'b0;
        end
      default: begin
        // Pulse SCL while SDA reads low, up to the pulse limit, then stop.
        if (phase_q == 6'd1) begin
          phase_q = (int'(pulse_q) < RECOVER_PULSES) ? 6'd2 : 6'd5;
          return 1'b0;
        end
        if (phase_q == 6'd2) begin
          phase_q = (shift_q == 8'd0) ? 6'd3 : 6'd5;
          return 1'b0;
        end
        if (phase_q == 6'd4) begin
          pulse_q = pulse_q + 4'd1;
          phase_q = (int'(pulse_q) < RECOVER_PULSES) ? 6'd2 : 6'd5;
          return 1'b0;
        end
        if (phase_q >= 6'd7) return 1'b1;
      end
    endcase
    phase_q = phase_q + 6'd1;
    return 1'b0;
  endfunction

  function automatic res_t step_sequencer(item_t it);
    res_t r;
    logic done, rej;
    done = 1'b0;
    rej  = 1'b0;
    if (it.mode != CMD_TICK) begin
      if (cmd_q != CMD_TICK) begin
        rej = 1'b1;
      end else begin
        cmd_q   = it.mode;
        phase_q = '0;
        wait_q  = '0;
        bit_q   = '0;
        pulse_q = '0;
        shift_q = (it.mode == CMD_WRITE)    ? it.data_byte :
                  (it.mode == CMD_SEND_ACK) ? {7'd0, it.ack_bit} : 8'd0;
      end
    end else if (cmd_q != CMD_TICK) begin
      if (wait_q == '0) begin
        run_phase(it.sda_in);
        wait_q = (delay_cfg == '0) ? DELAY_W'(1) : delay_cfg;
      end
      wait_q = wait_q - DELAY_W'(1);
      if (wait_q == '0 && next_phase()) begin
        cmd_q   = CMD_TICK;
        phase_q = '0;
        done    = 1'b1;
      end
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.busy_res  = (cmd_q != CMD_TICK);
    r.done_res  = done;
    r.read_byte = rx_q;
    r.ack_seen  = ack_q;
    r.rejected  = rej;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_cfg = DELAY_RST;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      cmd_q     = CMD_TICK;
      phase_q   = '0;
      wait_q    = '0;
      bit_q     = '0;
      pulse_q   = '0;
      shift_q   = '0;
      ack_q     = 1'b0;
      rx_q      = '0;
      n_err     = 0;
      n_items   = 0;
      n_done    = 0;
      n_rej     = 0;
      pin_result_q.delete();
    end else begin
      if (cfg_we_i) delay_cfg = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) begin
        pin_result_q.push_back(step_sequencer(item_t'({s_tdata_i[9:0], s_tuser_i})));
        n_items++;
      end
      if (m_tvalid_i && m_tready_i) begin
        got = res_t'(m_tdata_i[13:0]);
        if (pin_result_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result %h with nothing pending", m_tdata_i);
        end else begin
          want = pin_result_q.pop_front();
          if (want.done_res) n_done++;
          if (want.rejected) n_rej++;
          // Padding bits must read zero alongside every field.
          if ({m_tdata_i[15:14], got} !== {2'b00, want}) begin
            n_err++;
            if (n_err <= 10) begin
              $display("mismatch exp scl=%b sda=%b busy=%b done=%b rd=%h ack=%b rej=%b pad=00",
                       want.scl_level, want.sda_level, want.busy_res, want.done_res,
                       want.read_byte, want.ack_seen, want.rejected);
              $display("         got scl=%b sda=%b busy=%b done=%b rd=%h ack=%b rej=%b pad=%b",
                       got.scl_level, got.sda_level, got.busy_res, got.done_res,
                       got.read_byte, got.ack_seen, got.rejected, m_tdata_i[15:14]);
            end
          end
        end
      end
    end
    busy_o    <= (cmd_q != CMD_TICK);
    pending_o <= pin_result_q.size();
    errors_o  <= n_err;
    items_o   <= n_items;
    done_o    <= n_done;
    rejects_o <= n_rej;
  end

endmodule

>>> bench/i2c_master_bit_engine_test.sv
module i2c_master_bit_engine_test;
  import i2cbe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // How a run of ticks drives the sampled SDA line.
  typedef enum int {
    SDA_RANDOM,
    SDA_LOW,
    SDA_HIGH,
    SDA_MOSTLY_LOW
  } sda_style_e;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata;   // [7:0] data_byte, [8] ack_bit, [9] sda_in
  logic [2:0]         s_axis_tuser;   // [2:0] mode
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;   // [0] scl, [1] sda, [2] busy, [3] done,
                                      // [11:4] read_byte, [12] ack_seen, [13] rejected
  logic               cfg_we;
  logic [DELAY_W-1:0] cfg_wdata;

  // Predicted busy, one accepted item behind the item being taken.
  logic seq_busy;
  int   pending, errors, items, done_cnt, reject_cnt;

  // Handshake pressure, in percent per cycle, and rate of commands fired into a busy engine.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned noise_pct = 0;

  i2c_master_bit_engine u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  i2c_master_bit_engine_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .busy_o      (seq_busy),
    .pending_o   (pending),
    .errors_o    (errors),
    .items_o     (items),
    .done_o      (done_cnt),
    .rejects_o   (reject_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Stall the result channel at the current rate; zero means always ready.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #4_000_000;
    $display("i2c_master_bit_engine_test: FAIL");
    $finish;
  end

  // Offer one item, with random idle cycles ahead of it, and hold it until taken.
  // Valid stays high into the next item when no gap is drawn.
  task automatic send_item(cmd_e mode, logic [7:0] data, logic ack, logic line);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {6'd0, line, ack, data};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Feed ticks until the engine is idle again. Busy lags by one item, so the
  // loop ends on one item offered to the idle engine. Noise commands that land
  // while a command runs should be rejected; one offered to an idle engine loads.
  task automatic tick_until_idle(sda_style_e style);
    logic line, more;
    more = 1'b1;
    while (more) begin
      case (style)
        SDA_LOW:        line = 1'b0;
        SDA_HIGH:       line = 1'b1;
        SDA_MOSTLY_LOW: line = ($urandom_range(7) == 0);
        default:        line = 1'($urandom_range(1));
      endcase
      if ($urandom_range(99) < noise_pct)
        send_item(cmd_e'($urandom_range(7, 1)), 8'($urandom), 1'($urandom_range(1)), line);
      else
        send_item(CMD_TICK, 8'($urandom), 1'($urandom_range(1)), line);
      more = seq_busy;
    end
  endtask

  task automatic run_command(cmd_e cmd, logic [7:0] data, logic ack, sda_style_e style);
    send_item(cmd, data, ack, 1'($urandom_range(1)));
    tick_until_idle(style);
  endtask

  task automatic random_command();
    run_command(cmd_e'($urandom_range(7, 1)), 8'($urandom), 1'($urandom_range(1)),
                sda_style_e'($urandom_range(3)));
  endtask

  // Write delay_ticks with the engine idle and every result drained.
  task automatic write_delay(logic [DELAY_W-1:0] value);
    noise_pct = 0;
    // Flush any command that a late noise item loaded.
    tick_until_idle(SDA_RANDOM);
    s_axis_tvalid <= 1'b0;
    // Let the pending count catch up with the item just taken.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int rand_base, phase_end, mix;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_TICK;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ticks on an idle engine change nothing.
    send_item(CMD_TICK, 8'hFF, 1'b1, 1'b1);
    send_item(CMD_TICK, 8'h00, 1'b0, 1'b0);
    // Run one stop on the reset delay of 60 ticks per phase.
    run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);

    // Directed pass at one tick per phase: every command and its corner values.
    write_delay(DELAY_W'(1));
    run_command(CMD_WRITE, 8'h00, 1'b0, SDA_RANDOM);
    run_command(CMD_WRITE, 8'hFF, 1'b1, SDA_RANDOM);
    run_command(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
    run_command(CMD_READ, 8'h5A, 1'b1, SDA_HIGH);
    run_command(CMD_READ, 8'hFF, 1'b0, SDA_LOW);
    run_command(CMD_READ, 8'h00, 1'b1, SDA_RANDOM);
    run_command(CMD_SEND_ACK, 8'hFF, 1'b0, SDA_RANDOM);
    run_command(CMD_SEND_ACK, 8'h00, 1'b1, SDA_RANDOM);
    run_command(CMD_RECV_ACK, 8'h00, 1'b0, SDA_HIGH);
    run_command(CMD_RECV_ACK, 8'hFF, 1'b1, SDA_LOW);
    run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
    run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
    // Recovery: SDA stuck low hits the pulse limit, SDA high skips the pulses.
    run_command(CMD_RECOVER, 8'h00, 1'b0, SDA_LOW);
    run_command(CMD_RECOVER, 8'hFF, 1'b1, SDA_HIGH);
    run_command(CMD_RECOVER, 8'h00, 1'b0, SDA_MOSTLY_LOW);
    // A command that follows straight on while busy is rejected.
    send_item(CMD_START, 8'h00, 1'b0, 1'b0);
    send_item(CMD_RECOVER, 8'hFF, 1'b1, 1'b1);
    tick_until_idle(SDA_RANDOM);

    // A delay of zero behaves as one tick.
    write_delay(DELAY_W'(0));
    repeat (6) random_command();

    // Random phases: short delays, rotating through the handshake mixes.
    rand_base = items;
    mix       = 0;
    while (items - rand_base < 360) begin
      write_delay(DELAY_W'($urandom_range(4, 1)));
      case (mix % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 74; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 8;  stall_pct = 8;  end
      endcase
      mix++;
      noise_pct = 5;
      phase_end = items + 90;
      while (items < phase_end) random_command();
    end

    // Drain: bring the engine to idle, release the channel, wait for every result.
    noise_pct = 0;
    tick_until_idle(SDA_RANDOM);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("run covered %0d items over %0d handshake mixes: %0d commands completed, %0d rejected",
             items, mix, done_cnt, reject_cnt);
    $display("delays: reset value, 0, 1 and random 1..4; %0d result mismatches", errors);
    if (errors == 0 && pending == 0) begin
      $display("i2c_master_bit_engine_test: PASS");
    end else begin
      $display("i2c_master_bit_engine_test: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/i2cbe_pkg.sv
hw/rtl/i2cbe_seq.sv
hw/rtl/i2c_master_bit_engine.sv
hw/rtl/i2cbe_checker.sv
bench/i2c_master_bit_engine_checker.sv
bench/i2c_master_bit_engine_test.sv
